// ----- sv/ics_pkg.sv -----
package ics_pkg;

	localparam logic [15:0] PROTO_TCP = 16'd6;

	// One queued item, as classified by the front part.
	typedef struct packed {
		logic        opcode;
		logic        first_item;
		logic        has_byte;
		logic [7:0]  data_byte;
		logic        last_item;
		logic [15:0] pseudo_sum;
	} ics_item_t;

	// Folds a sum of up to eight 16-bit terms into a 16-bit ones'-complement value.
	function automatic logic [15:0] ics_fold(input logic [18:0] x);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, x[15:0]} + {14'd0, x[18:16]};
		f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
		return f2[15:0];
	endfunction

endpackage

// ----- sv/ics_front.sv -----
module ics_front (
	input  logic                 opcode,
	input  logic                 first_item,
	input  logic                 has_byte,
	input  logic [7:0]           data_byte,
	input  logic                 last_item,
	input  logic [31:0]          source_address,
	input  logic [31:0]          dest_address,
	output ics_pkg::ics_item_t   item
);

	logic [18:0] pseudo_raw;

	// Pseudo-header terms: both address halves of each address and the protocol.
	assign pseudo_raw = {3'd0, source_address[31:16]} + {3'd0, source_address[15:0]}
		+ {3'd0, dest_address[31:16]} + {3'd0, dest_address[15:0]}
		+ {3'd0, ics_pkg::PROTO_TCP};

	always_comb begin
		item.opcode     = opcode;
		item.first_item = first_item;
		item.has_byte   = has_byte;
		item.data_byte  = data_byte;
		item.last_item  = last_item;
		item.pseudo_sum = ics_pkg::ics_fold(pseudo_raw);
	end

endmodule

// ----- sv/ics_queue.sv -----
module ics_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ics_pkg::ics_item_t push_item,
	output logic               full,
	input  logic               pop,
	output ics_pkg::ics_item_t head,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ics_pkg::ics_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

// ----- sv/ics_back.sv -----
module ics_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ics_pkg::ics_item_t head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        out_sum
);

	logic [15:0] sum_q;
	logic [7:0]  pend_q;
	logic        odd_q;
	logic [15:0] cnt_q;
	logic        mode_q;
	logic        out_valid_q;
	logic [15:0] out_sum_q;

	logic [15:0] base;
	logic [7:0]  pend_b;
	logic        pend_v;
	logic [15:0] cnt_b;
	logic        mode_b;
	logic [15:0] term;
	logic [15:0] pad;
	logic [7:0]  pend_n;
	logic        odd_n;
	logic [15:0] cnt_n;
	logic [15:0] sum_n;
	logic [15:0] final_sum;

	// A result-bearing item waits while the output register is occupied and out_ready is low.
	assign pop = !empty && (!head.last_item || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

	always_comb begin
		base   = head.first_item ? (head.opcode ? head.pseudo_sum : 16'd0) : sum_q;
		pend_b = head.first_item ? 8'd0 : pend_q;
		pend_v = head.first_item ? 1'b0 : odd_q;
		cnt_b  = head.first_item ? 16'd0 : cnt_q;
		mode_b = head.first_item ? head.opcode : mode_q;
		term   = 16'd0;
		pend_n = pend_b;
		odd_n  = pend_v;
		cnt_n  = cnt_b;
		if (head.has_byte) begin
			cnt_n = cnt_b + 16'd1;
			if (pend_v) begin
				term   = {pend_b, head.data_byte};
				pend_n = 8'd0;
				odd_n  = 1'b0;
			end else begin
				pend_n = head.data_byte;
				odd_n  = 1'b1;
			end
		end
		pad       = odd_n ? {pend_n, 8'd0} : 16'd0;
		sum_n     = ics_pkg::ics_fold({3'd0, base} + {3'd0, term});
		final_sum = ics_pkg::ics_fold({3'd0, base} + {3'd0, term} + {3'd0, pad}
			+ {3'd0, (mode_b ? cnt_n : 16'd0)});
	end

	always_ff @(posedge clk) begin
		if (pop && head.last_item) begin
			out_sum_q <= ~final_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			pend_q      <= '0;
			odd_q       <= 1'b0;
			cnt_q       <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last_item) begin
					sum_q  <= '0;
					pend_q <= '0;
					odd_q  <= 1'b0;
					cnt_q  <= '0;
					mode_q <= 1'b0;
				end else begin
					sum_q  <= sum_n;
					pend_q <= pend_n;
					odd_q  <= odd_n;
					cnt_q  <= cnt_n;
					mode_q <= mode_b;
				end
			end
			if (pop && head.last_item) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last_item) |=> (sum_q == 16'd0 && !odd_q && cnt_q == 16'd0 && !mode_q))
		else $error("message state not cleared after the last item");

	a_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!odd_q |-> (pend_q == 8'd0))
		else $error("pending byte held without an odd byte waiting");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(pop && head.last_item))
		else $error("result overwritten before it was taken");

endmodule

// ----- sv/internet_checksum_tcp_pseudo.sv -----
// Output: a result is presented on m_axis_tvalid from the output register, which is loaded
// when the back part pops the last item from the queue head.
// Throughput: one input transaction per cycle while the queue is not full, set by the
// end-around-carry adder in the back part; a stalled result output holds a last item at the
// queue head, which blocks the back part and, once the queue is full, the input.
// Reset: arst_n clears the queue, the running sum, the byte count, the mode and the output valid.
module internet_checksum_tcp_pseudo #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // data_byte [7:0], source_address [39:8], dest_address [71:40]
	input  logic [2:0]  s_axis_tuser,  // opcode [0], first_item [1], has_byte [2]
	input  logic        s_axis_tlast,  // last_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // checksum [15:0]
);

	// The front part splits the transaction into its fields and works out the
	// folded pseudo-header sum (both address halves and the protocol number) so
	// that the back part needs only a single add per byte.
	ics_pkg::ics_item_t front_item;
	ics_pkg::ics_item_t head_item;
	logic               queue_full;
	logic               queue_empty;
	logic               queue_pop;
	logic               accept;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && !queue_full;

	ics_front u_front (
		.opcode         (s_axis_tuser[0]),
		.first_item     (s_axis_tuser[1]),
		.has_byte       (s_axis_tuser[2]),
		.data_byte      (s_axis_tdata[7:0]),
		.last_item      (s_axis_tlast),
		.source_address (s_axis_tdata[39:8]),
		.dest_address   (s_axis_tdata[71:40]),
		.item           (front_item)
	);

	// The short queue lets the input keep flowing while a finished checksum waits
	// on the output side.
	ics_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.head      (head_item),
		.empty     (queue_empty)
	);

	// The back part holds the message state: running sum, unpaired high byte,
	// byte count and mode. On a last item it adds any zero-padded odd byte and,
	// in TCP mode, the byte count, then registers the complemented sum.
	ics_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_item),
		.empty     (queue_empty),
		.pop       (queue_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sum   (m_axis_tdata)
	);

endmodule
